>>> src/dlsp_pkg.sv
// Shared types, constants and helpers of the debounced lamp servo presser.
package dlsp_pkg;

    localparam int CHANNELS = 2;

    localparam int CNT_W = 16;
    localparam int ANG_W = 8;
    localparam int PER_W = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_PERIOD_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DEGREES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REST_ANGLE_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REST_ANGLE_B = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_ANGLE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_ANGLE_B = 3'd7;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CNT_W-1:0] PERIOD_RST = 16'd50;
    localparam logic [ANG_W-1:0] STEP_RST = 8'd5;
    localparam logic [CNT_W-1:0] IDLE_RST = 16'd5000;
    localparam logic [ANG_W-1:0] REST_A_RST = 8'd180;
    localparam logic [ANG_W-1:0] REST_B_RST = 8'd0;
    localparam logic [ANG_W-1:0] PRESS_A_RST = 8'd65;
    localparam logic [ANG_W-1:0] PRESS_B_RST = 8'd115;

    localparam logic [ANG_W-1:0] ANGLE_MAX = 8'd180;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [ANG_W-1:0] step_degrees;
        logic [ANG_W-1:0] rest_angle;
        logic [ANG_W-1:0] press_angle;
    } lane_cfg_t;

    // what a lane found on the current tick
    typedef struct packed {
        logic settle;
        logic move;
    } lane_flags_t;

    // shared decisions fed back to every lane
    typedef struct packed {
        logic pass;
        logic idle_clr;
    } pass_ctl_t;

    function automatic logic [ANG_W-1:0] cap_angle(input logic [ANG_W-1:0] a);
        cap_angle = (a > ANGLE_MAX) ? ANGLE_MAX : a;
    endfunction

endpackage

>>> src/dlsp_lane.sv
// One channel: sensor debounce, wanted level and servo stepping.
module dlsp_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_fire,
    input  logic                          item_is_cmd,
    input  logic                          cmd_hit,
    input  logic                          cmd_on,
    input  logic                          raw_level,
    input  logic                          lane_on,
    input  logic [dlsp_pkg::ANG_W-1:0]    angle_rst,
    input  dlsp_pkg::lane_cfg_t           cfg,
    input  dlsp_pkg::pass_ctl_t           ctl,
    output dlsp_pkg::lane_flags_t         flags,
    output logic                          lamp,
    output logic [dlsp_pkg::ANG_W-1:0]    angle,
    output logic                          driven
);

    logic                        settled_reg, settled_next;
    logic                        cand_reg, cand_next;
    logic                        running_reg, running_next;
    logic [dlsp_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        ready_reg, ready_next;
    logic                        wanted_reg, wanted_next;
    logic [dlsp_pkg::ANG_W-1:0]  angle_reg, angle_next;
    logic                        driven_reg, driven_next;

    logic                        tick;
    logic                        settle_now;
    logic                        move_now;
    logic [dlsp_pkg::ANG_W-1:0]  target;
    logic [dlsp_pkg::ANG_W+1:0]  up_sum;
    logic [dlsp_pkg::ANG_W+1:0]  down_floor;
    logic [dlsp_pkg::ANG_W-1:0]  stepped;

    assign tick = item_fire && (item_is_cmd == dlsp_pkg::OP_TICK) && lane_on;

    always_comb begin
        settled_next = settled_reg;
        cand_next    = cand_reg;
        running_next = running_reg;
        count_next   = count_reg;
        ready_next   = ready_reg;
        wanted_next  = wanted_reg;
        settle_now   = 1'b0;

        if (tick) begin
            if ((raw_level != cand_reg) || (!ready_reg && !running_reg)) begin
                cand_next    = raw_level;
                running_next = 1'b1;
                count_next   = '0;
            end else if (running_reg) begin
                if (count_reg >= cfg.debounce_ticks) begin
                    settled_next = cand_reg;
                    if (!ready_reg) begin
                        wanted_next = cand_reg;
                        ready_next  = 1'b1;
                    end
                    running_next = 1'b0;
                    settle_now   = 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
        end

        if (item_fire && (item_is_cmd == dlsp_pkg::OP_COMMAND) && cmd_hit && lane_on) begin
            wanted_next = cmd_on;
        end
    end

    // step toward the target, never past it
    always_comb begin
        target = dlsp_pkg::cap_angle((settled_next == wanted_next) ? cfg.rest_angle
                                                                   : cfg.press_angle);
        up_sum     = {2'b00, angle_reg} + {2'b00, cfg.step_degrees};
        down_floor = {2'b00, target} + {2'b00, cfg.step_degrees};
        if (target > angle_reg) begin
            stepped = (up_sum > {2'b00, target}) ? target : up_sum[dlsp_pkg::ANG_W-1:0];
        end else begin
            stepped = ({2'b00, angle_reg} < down_floor) ? target
                                                        : angle_reg - cfg.step_degrees;
        end
        move_now = tick && ready_next && (stepped != angle_reg);
    end

    assign flags = '{settle: settle_now, move: move_now};

    always_comb begin
        angle_next  = angle_reg;
        driven_next = driven_reg;
        if (tick && ctl.pass && move_now) begin
            angle_next  = stepped;
            driven_next = 1'b1;
        end else if (tick && ctl.idle_clr) begin
            driven_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settled_reg <= 1'b0;
            cand_reg    <= 1'b0;
            running_reg <= 1'b0;
            count_reg   <= '0;
            ready_reg   <= 1'b0;
            wanted_reg  <= 1'b0;
            angle_reg   <= angle_rst;
            driven_reg  <= 1'b1;
        end else begin
            settled_reg <= settled_next;
            cand_reg    <= cand_next;
            running_reg <= running_next;
            count_reg   <= count_next;
            ready_reg   <= ready_next;
            wanted_reg  <= wanted_next;
            angle_reg   <= angle_next;
            driven_reg  <= driven_next;
        end
    end

    assign lamp   = settled_reg;
    assign angle  = angle_reg;
    assign driven = driven_reg;

endmodule

>>> src/dlsp_merge.sv
// Shared period and idle counters; merges lane flags into pass decisions.
module dlsp_merge (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   tick_fire,
    input  dlsp_pkg::lane_flags_t                  flags [dlsp_pkg::CHANNELS],
    input  logic [dlsp_pkg::CNT_W-1:0]             servo_period_ticks,
    input  logic [dlsp_pkg::CNT_W-1:0]             idle_ticks,
    output dlsp_pkg::pass_ctl_t                    ctl
);

    logic [dlsp_pkg::PER_W-1:0] period_reg, period_next;
    logic [dlsp_pkg::PER_W-1:0] still_reg, still_next;
    logic [dlsp_pkg::PER_W-1:0] period_inc, still_inc;
    logic                       any_settle, any_move;
    logic                       pass_now, idle_now;

    always_comb begin
        any_settle = 1'b0;
        any_move   = 1'b0;
        for (int c = 0; c < dlsp_pkg::CHANNELS; c++) begin
            any_settle = any_settle | flags[c].settle;
            any_move   = any_move | flags[c].move;
        end
    end

    // counters saturate at all ones
    assign period_inc = (&period_reg) ? period_reg : period_reg + 1'b1;
    assign still_inc  = (&still_reg) ? still_reg : still_reg + 1'b1;

    assign idle_now = still_inc > {1'b0, idle_ticks};
    assign pass_now = any_settle || (period_inc > {1'b0, servo_period_ticks});
    assign ctl      = '{pass: pass_now, idle_clr: idle_now};

    always_comb begin
        period_next = period_reg;
        still_next  = still_reg;
        if (tick_fire) begin
            period_next = pass_now ? '0 : period_inc;
            still_next  = (pass_now && any_move) ? '0 : still_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
            still_reg  <= '0;
        end else begin
            period_reg <= period_next;
            still_reg  <= still_next;
        end
    end

endmodule

>>> src/debounced_lamp_servo_presser.sv
// Latency: a result word is valid the cycle after its input word is accepted.
// Throughput: one word per cycle while no result word is held back; each lane's state update is registered.
// Lane state registers double as the output register; a new word is taken while
// the pending result is taken in the same cycle.
// Reset (aresetn low, synchronous): registers to defaults, servos at rest, driven.
module debounced_lamp_servo_presser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic                                s_sensor_level_a,
    input  logic                                s_sensor_level_b,
    input  logic                                s_command_channel,
    input  logic                                s_command_on,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_lamp_a,
    output logic                                m_lamp_b,
    output logic [dlsp_pkg::ANG_W-1:0]          m_angle_a,
    output logic [dlsp_pkg::ANG_W-1:0]          m_angle_b,
    output logic                                m_drive_enable_a,
    output logic                                m_drive_enable_b,
    output logic                                m_settled_on_a,
    output logic                                m_settled_on_b,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dlsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [dlsp_pkg::CNT_W-1:0] debounce_reg, period_cfg_reg, idle_reg;
    logic [dlsp_pkg::ANG_W-1:0] step_reg;
    logic [dlsp_pkg::ANG_W-1:0] rest_reg  [2];
    logic [dlsp_pkg::ANG_W-1:0] press_reg [2];
    logic                       m_valid_reg, m_valid_next;

    logic                       accept;
    logic                       cfg_we;
    dlsp_pkg::lane_cfg_t        lane_cfg   [2];
    dlsp_pkg::lane_flags_t      lane_flags [2];
    dlsp_pkg::lane_flags_t      merge_flags [dlsp_pkg::CHANNELS];
    dlsp_pkg::pass_ctl_t        ctl;
    logic                       raw   [2];
    logic                       lamp  [2];
    logic [dlsp_pkg::ANG_W-1:0] angle [2];
    logic                       driven [2];
    logic [dlsp_pkg::ANG_W-1:0] angle_rst [2];

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= dlsp_pkg::DEBOUNCE_RST;
            period_cfg_reg <= dlsp_pkg::PERIOD_RST;
            step_reg       <= dlsp_pkg::STEP_RST;
            idle_reg       <= dlsp_pkg::IDLE_RST;
            rest_reg[0]    <= dlsp_pkg::REST_A_RST;
            rest_reg[1]    <= dlsp_pkg::REST_B_RST;
            press_reg[0]   <= dlsp_pkg::PRESS_A_RST;
            press_reg[1]   <= dlsp_pkg::PRESS_B_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                dlsp_pkg::REG_DEBOUNCE_TICKS:     debounce_reg   <= cfg_data;
                dlsp_pkg::REG_SERVO_PERIOD_TICKS: period_cfg_reg <= cfg_data;
                dlsp_pkg::REG_STEP_DEGREES:       step_reg       <= cfg_data[7:0];
                dlsp_pkg::REG_IDLE_TICKS:         idle_reg       <= cfg_data;
                dlsp_pkg::REG_REST_ANGLE_A:       rest_reg[0]    <= cfg_data[7:0];
                dlsp_pkg::REG_REST_ANGLE_B:       rest_reg[1]    <= cfg_data[7:0];
                dlsp_pkg::REG_PRESS_ANGLE_A:      press_reg[0]   <= cfg_data[7:0];
                dlsp_pkg::REG_PRESS_ANGLE_B:      press_reg[1]   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign raw[0]       = s_sensor_level_a;
    assign raw[1]       = s_sensor_level_b;
    assign angle_rst[0] = dlsp_pkg::REST_A_RST;
    assign angle_rst[1] = dlsp_pkg::REST_B_RST;

    for (genvar c = 0; c < 2; c++) begin : g_lane
        assign lane_cfg[c].debounce_ticks = debounce_reg;
        assign lane_cfg[c].step_degrees   = step_reg;
        assign lane_cfg[c].rest_angle     = rest_reg[c];
        assign lane_cfg[c].press_angle    = press_reg[c];

        dlsp_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .item_fire   (accept),
            .item_is_cmd (s_operation),
            .cmd_hit     (s_command_channel == 1'(c)),
            .cmd_on      (s_command_on),
            .raw_level   (raw[c]),
            .lane_on     (c < dlsp_pkg::CHANNELS),
            .angle_rst   (angle_rst[c]),
            .cfg         (lane_cfg[c]),
            .ctl         (ctl),
            .flags       (lane_flags[c]),
            .lamp        (lamp[c]),
            .angle       (angle[c]),
            .driven      (driven[c])
        );
    end

    for (genvar c = 0; c < dlsp_pkg::CHANNELS; c++) begin : g_flags
        assign merge_flags[c] = lane_flags[c];
    end

    dlsp_merge u_merge (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .tick_fire          (accept && (s_operation == dlsp_pkg::OP_TICK)),
        .flags              (merge_flags),
        .servo_period_ticks (period_cfg_reg),
        .idle_ticks         (idle_reg),
        .ctl                (ctl)
    );

    assign m_valid          = m_valid_reg;
    assign m_lamp_a         = lamp[0];
    assign m_lamp_b         = lamp[1];
    assign m_angle_a        = angle[0];
    assign m_angle_b        = angle[1];
    assign m_drive_enable_a = driven[0];
    assign m_drive_enable_b = driven[1];
    assign m_settled_on_a   = lamp[0];
    assign m_settled_on_b   = lamp[1];

endmodule

>>> src/dlsp_checker.sv
// Port-level checks of the presser, bound to the top level.
module dlsp_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_ready,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         m_lamp_a,
    input  logic                         m_settled_on_a,
    input  logic [dlsp_pkg::ANG_W-1:0]   m_angle_a,
    input  logic [dlsp_pkg::ANG_W-1:0]   m_angle_b
);

    // input side only stalls while a result word is held back
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output slot");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_angle_a <= dlsp_pkg::ANGLE_MAX) && (m_angle_b <= dlsp_pkg::ANGLE_MAX))
        else $error("servo angle out of range");

    a_lamp_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lamp_a == m_settled_on_a))
        else $error("lamp differs from settled level");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_angle_a) && $stable(m_angle_b)))
        else $error("stalled result word changed");

endmodule

bind debounced_lamp_servo_presser dlsp_checker u_dlsp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_lamp_a       (m_lamp_a),
    .m_settled_on_a (m_settled_on_a),
    .m_angle_a      (m_angle_a),
    .m_angle_b      (m_angle_b)
);

>>> sim/debounced_lamp_servo_presser_tb.sv
// Self-checking testbench for the debounced lamp servo presser.
`timescale 1ns / 100ps

module debounced_lamp_servo_presser_tb;

    localparam int STALL_LIMIT = 2000;
    localparam logic [dlsp_pkg::PER_W-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic op;
        logic level_a;
        logic level_b;
        logic chan;
        logic on;
    } presser_word_t;

    typedef struct packed {
        logic                       lamp_a;
        logic                       lamp_b;
        logic [dlsp_pkg::ANG_W-1:0] angle_a;
        logic [dlsp_pkg::ANG_W-1:0] angle_b;
        logic                       drive_a;
        logic                       drive_b;
        logic                       settled_a;
        logic                       settled_b;
    } presser_view_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_operation = dlsp_pkg::OP_TICK;
    logic                            s_sensor_level_a = 1'b0;
    logic                            s_sensor_level_b = 1'b0;
    logic                            s_command_channel = 1'b0;
    logic                            s_command_on = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b1;
    logic                            m_lamp_a;
    logic                            m_lamp_b;
    logic [dlsp_pkg::ANG_W-1:0]      m_angle_a;
    logic [dlsp_pkg::ANG_W-1:0]      m_angle_b;
    logic                            m_drive_enable_a;
    logic                            m_drive_enable_b;
    logic                            m_settled_on_a;
    logic                            m_settled_on_b;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dlsp_pkg::CFG_IDX_W-1:0]  cfg_index = dlsp_pkg::REG_DEBOUNCE_TICKS;
    logic [dlsp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    debounced_lamp_servo_presser u_top (.*);

    always #6 aclk = ~aclk;

    // predictor copy of the block's registers and state
    logic [dlsp_pkg::CNT_W-1:0] debounce_cfg, period_cfg, idle_cfg;
    logic [dlsp_pkg::ANG_W-1:0] step_cfg;
    logic [dlsp_pkg::ANG_W-1:0] rest_cfg [2];
    logic [dlsp_pkg::ANG_W-1:0] press_cfg [2];

    logic                       settled [2];
    logic                       cand [2];
    logic                       running [2];
    logic [dlsp_pkg::CNT_W-1:0] stable [2];
    logic                       ch_ready [2];
    logic                       wanted [2];
    logic                       lamp [2];
    logic [dlsp_pkg::ANG_W-1:0] angle [2];
    logic                       driven [2];
    logic [dlsp_pkg::PER_W-1:0] period_cnt, still_cnt;
    logic                       pass_forced;

    presser_word_t words_pending [$];
    presser_view_t expected_views [$];
    presser_word_t offered_word;
    presser_view_t got_view, want_view;

    logic word_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   mismatch_count = 0;
    int   results_seen = 0;
    int   quiet_cycles = 0;
    int   rx_cycle = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    rx_mode_t rx_mode = RX_OPEN;

    function automatic presser_view_t advance_presser(input presser_word_t w);
        presser_view_t v;
        logic raw [2];
        logic moved;
        logic [dlsp_pkg::ANG_W-1:0] aim;
        int pos, goal, nxt, c;
        if (w.op == dlsp_pkg::OP_COMMAND) begin
            wanted[w.chan] = w.on;
        end else begin
            raw[0] = w.level_a;
            raw[1] = w.level_b;
            moved = 1'b0;
            if (period_cnt != COUNT_TOP) period_cnt = period_cnt + 1'b1;
            if (still_cnt != COUNT_TOP) still_cnt = still_cnt + 1'b1;
            for (c = 0; c < dlsp_pkg::CHANNELS; c++) begin
                if (raw[c] != cand[c] || (!ch_ready[c] && !running[c])) begin
                    cand[c] = raw[c];
                    running[c] = 1'b1;
                    stable[c] = '0;
                end else if (running[c]) begin
                    if (stable[c] >= debounce_cfg) begin
                        settled[c] = cand[c];
                        lamp[c] = cand[c];
                        if (!ch_ready[c]) begin
                            wanted[c] = cand[c];
                            ch_ready[c] = 1'b1;
                        end
                        running[c] = 1'b0;
                        pass_forced = 1'b1;
                    end else begin
                        stable[c] = stable[c] + 1'b1;
                    end
                end
            end
            if (still_cnt > idle_cfg) begin
                driven[0] = 1'b0;
                driven[1] = 1'b0;
            end
            if (pass_forced || period_cnt > period_cfg) begin
                period_cnt = '0;
                pass_forced = 1'b0;
                for (c = 0; c < dlsp_pkg::CHANNELS; c++) begin
                    if (ch_ready[c]) begin
                        aim = (settled[c] == wanted[c]) ? rest_cfg[c] : press_cfg[c];
                        if (aim > dlsp_pkg::ANGLE_MAX) aim = dlsp_pkg::ANGLE_MAX;
                        pos = angle[c];
                        goal = aim;
                        if (goal > pos) begin
                            nxt = pos + step_cfg;
                            if (nxt > goal) nxt = goal;
                        end else begin
                            nxt = pos - step_cfg;
                            if (nxt < goal) nxt = goal;
                        end
                        angle[c] = nxt[dlsp_pkg::ANG_W-1:0];
                        if (nxt != pos) begin
                            driven[c] = 1'b1;
                            moved = 1'b1;
                        end
                    end
                end
                if (moved) still_cnt = '0;
            end
        end
        v.lamp_a = lamp[0];
        v.lamp_b = lamp[1];
        v.angle_a = angle[0];
        v.angle_b = angle[1];
        v.drive_a = driven[0];
        v.drive_b = driven[1];
        v.settled_a = settled[0];
        v.settled_b = settled[1];
        return v;
    endfunction

    function automatic presser_word_t tick_word(input logic a, input logic b);
        presser_word_t w;
        w = '0;
        w.op = dlsp_pkg::OP_TICK;
        w.level_a = a;
        w.level_b = b;
        return w;
    endfunction

    function automatic presser_word_t cmd_word(input logic ch, input logic on);
        presser_word_t w;
        w = '0;
        w.op = dlsp_pkg::OP_COMMAND;
        w.chan = ch;
        w.on = on;
        // idle sensor bits get noise, the block must not look at them
        w.level_a = 1'($urandom_range(0, 1));
        w.level_b = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch: %s", what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d at result %0d",
                                      name, got, want, results_seen));
    endtask

    task automatic wait_drained();
        while (words_pending.size() != 0 || s_valid || expected_views.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic program_settings(input logic [dlsp_pkg::CNT_W-1:0] deb,
                                    input logic [dlsp_pkg::CNT_W-1:0] per,
                                    input logic [dlsp_pkg::ANG_W-1:0] step,
                                    input logic [dlsp_pkg::CNT_W-1:0] idle,
                                    input logic [dlsp_pkg::ANG_W-1:0] ra,
                                    input logic [dlsp_pkg::ANG_W-1:0] rb,
                                    input logic [dlsp_pkg::ANG_W-1:0] pa,
                                    input logic [dlsp_pkg::ANG_W-1:0] pb);
        logic [dlsp_pkg::CFG_IDX_W-1:0]  idx [8];
        logic [dlsp_pkg::CFG_DATA_W-1:0] val [8];
        int k;
        idx[0] = dlsp_pkg::REG_DEBOUNCE_TICKS;     val[0] = deb;
        idx[1] = dlsp_pkg::REG_SERVO_PERIOD_TICKS; val[1] = per;
        idx[2] = dlsp_pkg::REG_STEP_DEGREES;       val[2] = {8'd0, step};
        idx[3] = dlsp_pkg::REG_IDLE_TICKS;         val[3] = idle;
        idx[4] = dlsp_pkg::REG_REST_ANGLE_A;       val[4] = {8'd0, ra};
        idx[5] = dlsp_pkg::REG_REST_ANGLE_B;       val[5] = {8'd0, rb};
        idx[6] = dlsp_pkg::REG_PRESS_ANGLE_A;      val[6] = {8'd0, pa};
        idx[7] = dlsp_pkg::REG_PRESS_ANGLE_B;      val[7] = {8'd0, pb};
        for (k = 0; k < 8; k++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[k])
                dlsp_pkg::REG_DEBOUNCE_TICKS:     debounce_cfg = val[k];
                dlsp_pkg::REG_SERVO_PERIOD_TICKS: period_cfg = val[k];
                dlsp_pkg::REG_STEP_DEGREES:       step_cfg = val[k][dlsp_pkg::ANG_W-1:0];
                dlsp_pkg::REG_IDLE_TICKS:         idle_cfg = val[k];
                dlsp_pkg::REG_REST_ANGLE_A:       rest_cfg[0] = val[k][dlsp_pkg::ANG_W-1:0];
                dlsp_pkg::REG_REST_ANGLE_B:       rest_cfg[1] = val[k][dlsp_pkg::ANG_W-1:0];
                dlsp_pkg::REG_PRESS_ANGLE_A:      press_cfg[0] = val[k][dlsp_pkg::ANG_W-1:0];
                dlsp_pkg::REG_PRESS_ANGLE_B:      press_cfg[1] = val[k][dlsp_pkg::ANG_W-1:0];
                default: ;
            endcase
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // sensor levels are held for spans around the debounce time so that they settle,
    // with commands and single-tick glitches mixed in
    task automatic queue_phase(input int n, input int deb);
        int hold [2];
        logic lvl [2];
        int span, i, c, r;
        span = (deb > 30) ? 30 : deb;
        for (c = 0; c < 2; c++) begin
            lvl[c] = 1'($urandom_range(0, 1));
            hold[c] = $urandom_range(0, 2 * span + 4);
        end
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                words_pending.push_back(cmd_word(1'($urandom_range(0, 1)),
                                                 1'($urandom_range(0, 1))));
            end else if (r < 14) begin
                words_pending.push_back(tick_word(1'($urandom_range(0, 1)),
                                                  1'($urandom_range(0, 1))));
            end else begin
                words_pending.push_back(tick_word(lvl[0], lvl[1]));
                for (c = 0; c < 2; c++) begin
                    if (hold[c] == 0) begin
                        if ($urandom_range(0, 3) != 0) lvl[c] = ~lvl[c];
                        hold[c] = $urandom_range(0, 2 * span + 4);
                    end else begin
                        hold[c]--;
                    end
                end
            end
        end
    endtask

    // sender: bursts of words separated by random gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || word_taken)) begin
            word_taken = 1'b0;
            if (gap_left != 0 || words_pending.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                offered_word = words_pending.pop_front();
                s_operation <= offered_word.op;
                s_sensor_level_a <= offered_word.level_a;
                s_sensor_level_b <= offered_word.level_b;
                s_command_channel <= offered_word.chan;
                s_command_on <= offered_word.on;
                s_valid <= 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                              : $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 5);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_views.push_back(advance_presser(offered_word));
            word_taken = 1'b1;
        end
    end

    // receiver: stall pattern changes every so often, plus long hold-offs
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (s_valid && ((!hold_done && results_seen >= 150) ||
                                 $urandom_range(0, 799) == 0)) begin
            hold_done = 1'b1;
            hold_left = $urandom_range(60, 200);
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_cycle % 4 == 0);
                default:   m_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_views.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %0d", results_seen));
            end else begin
                want_view = expected_views.pop_front();
                got_view.lamp_a = m_lamp_a;
                got_view.lamp_b = m_lamp_b;
                got_view.angle_a = m_angle_a;
                got_view.angle_b = m_angle_b;
                got_view.drive_a = m_drive_enable_a;
                got_view.drive_b = m_drive_enable_b;
                got_view.settled_a = m_settled_on_a;
                got_view.settled_b = m_settled_on_b;
                check_field("lamp_a", got_view.lamp_a, want_view.lamp_a);
                check_field("lamp_b", got_view.lamp_b, want_view.lamp_b);
                check_field("angle_a", got_view.angle_a, want_view.angle_a);
                check_field("angle_b", got_view.angle_b, want_view.angle_b);
                check_field("drive_enable_a", got_view.drive_a, want_view.drive_a);
                check_field("drive_enable_b", got_view.drive_b, want_view.drive_b);
                check_field("settled_on_a", got_view.settled_a, want_view.settled_a);
                check_field("settled_on_b", got_view.settled_b, want_view.settled_b);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int p;
        debounce_cfg = dlsp_pkg::DEBOUNCE_RST;
        period_cfg = dlsp_pkg::PERIOD_RST;
        step_cfg = dlsp_pkg::STEP_RST;
        idle_cfg = dlsp_pkg::IDLE_RST;
        rest_cfg[0] = dlsp_pkg::REST_A_RST;
        rest_cfg[1] = dlsp_pkg::REST_B_RST;
        press_cfg[0] = dlsp_pkg::PRESS_A_RST;
        press_cfg[1] = dlsp_pkg::PRESS_B_RST;
        for (p = 0; p < 2; p++) begin
            settled[p] = 1'b0;
            cand[p] = 1'b0;
            running[p] = 1'b0;
            stable[p] = '0;
            ch_ready[p] = 1'b0;
            wanted[p] = 1'b0;
            lamp[p] = 1'b0;
            angle[p] = rest_cfg[p];
            driven[p] = 1'b1;
        end
        period_cnt = '0;
        still_cnt = '0;
        pass_forced = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: commands first, then every level pair
        words_pending.push_back(cmd_word(1'b0, 1'b1));
        words_pending.push_back(cmd_word(1'b1, 1'b1));
        words_pending.push_back(cmd_word(1'b0, 1'b0));
        words_pending.push_back(cmd_word(1'b1, 1'b0));
        words_pending.push_back(tick_word(1'b0, 1'b0));
        words_pending.push_back(tick_word(1'b1, 1'b1));
        words_pending.push_back(tick_word(1'b0, 1'b1));
        words_pending.push_back(tick_word(1'b1, 1'b0));
        wait_drained();

        // extremes: instant settle, pass every tick, full-swing step, disable at once
        program_settings(16'd0, 16'd0, 8'd180, 16'd0, 8'd0, 8'd180, 8'd180, 8'd0);
        words_pending.push_back(tick_word(1'b1, 1'b1));
        words_pending.push_back(tick_word(1'b1, 1'b1));
        words_pending.push_back(tick_word(1'b1, 1'b1));
        words_pending.push_back(tick_word(1'b0, 1'b0));
        words_pending.push_back(tick_word(1'b0, 1'b0));
        words_pending.push_back(tick_word(1'b0, 1'b0));
        words_pending.push_back(cmd_word(1'b0, 1'b0));
        words_pending.push_back(tick_word(1'b0, 1'b0));
        words_pending.push_back(cmd_word(1'b1, 1'b0));
        words_pending.push_back(cmd_word(1'b1, 1'b1));
        words_pending.push_back(tick_word(1'b1, 1'b0));
        words_pending.push_back(tick_word(1'b1, 1'b0));
        words_pending.push_back(tick_word(1'b0, 1'b1));
        words_pending.push_back(tick_word(1'b0, 1'b1));
        words_pending.push_back(tick_word(1'b0, 1'b0));
        words_pending.push_back(tick_word(1'b0, 1'b0));
        wait_drained();

        program_settings(16'd3, 16'd2, 8'd5, 16'd20, 8'd180, 8'd0, 8'd65, 8'd115);
        queue_phase(300, 3);
        wait_drained();

        program_settings(16'd0, 16'd0, 8'd180, 16'd0, 8'd0, 8'd180, 8'd180, 8'd0);
        queue_phase(200, 0);
        wait_drained();

        program_settings(16'd1, 16'd4, 8'd7, 16'hFFFF, 8'd90, 8'd45, 8'd10, 8'd170);
        queue_phase(250, 1);
        wait_drained();

        // angles beyond the travel range are clamped; only settle passes run
        program_settings(16'd2, 16'hFFFF, 8'd1, 16'd10, 8'd200, 8'd255, 8'd0, 8'd181);
        queue_phase(200, 2);
        wait_drained();

        // a zero step never moves the servos
        program_settings(16'd5, 16'd1, 8'd0, 16'd8, 8'd30, 8'd60, 8'd150, 8'd120);
        queue_phase(150, 5);
        wait_drained();

        program_settings(16'hFFFF, 16'd3, 8'd13, 16'd40, 8'd0, 8'd0, 8'd180, 8'd180);
        queue_phase(150, 65535);
        wait_drained();

        for (p = 0; p < 2; p++) begin
            program_settings(16'($urandom_range(0, 8)), 16'($urandom_range(0, 6)),
                             8'($urandom_range(1, 180)), 16'($urandom_range(0, 60)),
                             8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                             8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)));
            queue_phase(190, debounce_cfg);
            wait_drained();
        end

        repeat (5) @(posedge aclk);
        if (expected_views.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_views.size()));
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
